@@ design/ica_pkg.sv @@
// Package with shared types, constants and command codes of the integer calculator ALU.
`timescale 1ns / 1ps
package ica_pkg;
    localparam int DATA_WIDTH = 64;
    localparam int CNT_W = $clog2(DATA_WIDTH + 1);
    localparam int HALF_W = DATA_WIDTH / 2;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
        CMD_REM = 3'd4, CMD_POW = 3'd5, CMD_MIN = 3'd6, CMD_MAX = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [63:0] left_operand;
        logic signed [63:0] right_operand;
    } t_in;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic               status;
    } t_out;

    // Datapath operation requested by the controller.
    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_SIMPLE, OP_MUL_STEP, OP_DIV_STEP, OP_POW_STEP, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
        logic [1:0] part;   // partial product select for multiplies
        logic       sq;     // power: 1 squares the base, 0 multiplies into acc
    } t_ctrl;

    typedef struct packed {
        logic div_zero;
        logic exp_done;     // power exponent exhausted or negative
        logic exp_bit;      // current exponent low bit
    } t_stat;
endpackage

@@ design/ica_datapath.sv @@
// Datapath of the integer calculator ALU: operand registers, shift-subtract divider, multiplier.
`timescale 1ns / 1ps
module ica_datapath (
    input  logic          i_clk,
    input  ica_pkg::t_in  i_in,
    input  ica_pkg::t_ctrl i_ctrl,
    output ica_pkg::t_stat o_stat,
    output logic [ica_pkg::DATA_WIDTH-1:0] o_result,
    output logic          o_err
);
    localparam int W = ica_pkg::DATA_WIDTH;
    localparam int H = ica_pkg::HALF_W;

    logic [2:0]   r_cmd;
    logic [W-1:0] r_a, r_b, r_acc, r_rem, r_quo, r_x, r_y;
    logic         r_neg_q, r_neg_r, r_zero, r_eneg;

    // Multiplier operands: x * y, built from three partial products of 32-bit halves.
    logic [W-1:0] w_mx, w_my;
    logic [H-1:0] w_ma, w_mb;
    logic [W-1:0] w_pp, w_sh;
    logic [W:0]   w_trial;
    logic [W-1:0] w_rem_sh;
    logic [W-1:0] w_res;

    always_comb begin
        // Power multiplies acc by base, or squares the base; a multiply uses both operands.
        w_mx = (i_ctrl.op == ica_pkg::OP_POW_STEP && !i_ctrl.sq) ? r_acc : r_x;
        w_my = (i_ctrl.op == ica_pkg::OP_POW_STEP) ? r_x : r_y;
        w_ma = i_ctrl.part[0] ? w_mx[W-1:H] : w_mx[H-1:0];
        w_mb = i_ctrl.part[1] ? w_my[W-1:H] : w_my[H-1:0];
        w_pp = W'(w_ma) * W'(w_mb);
        w_sh = (i_ctrl.part == 2'd0) ? w_pp :
               (i_ctrl.part == 2'd3) ? '0 : (w_pp << H);
        w_rem_sh = {r_rem[W-2:0], r_quo[W-1]};
        w_trial = {1'b0, w_rem_sh} - {1'b0, r_b};
    end

    // Result selection for add, sub, min, max, div and rem; other commands take the accumulator.
    logic         w_le;
    always_comb begin
        w_le = $signed(r_a) <= $signed(r_b);
        case (r_cmd)
            ica_pkg::CMD_ADD: w_res = r_a + r_b;
            ica_pkg::CMD_SUB: w_res = r_a - r_b;
            ica_pkg::CMD_MIN: w_res = w_le ? r_a : r_b;
            ica_pkg::CMD_MAX: w_res = ($signed(r_b) <= $signed(r_a)) ? r_a : r_b;
            ica_pkg::CMD_DIV: w_res = r_zero ? '0 : (r_neg_q ? -r_quo : r_quo);
            ica_pkg::CMD_REM: w_res = r_zero ? '0 : (r_neg_r ? -r_rem : r_rem);
            default:          w_res = r_acc;
        endcase
    end

    // Register updates per controller command.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            ica_pkg::OP_LOAD: begin
                r_cmd  <= i_in.command;
                r_a    <= i_in.left_operand[W-1:0];
                r_zero <= i_in.right_operand[W-1:0] == '0;
                r_eneg <= i_in.right_operand[W-1];
                r_neg_q <= i_in.left_operand[W-1] ^ i_in.right_operand[W-1];
                r_neg_r <= i_in.left_operand[W-1];
                r_rem  <= '0;
                r_acc  <= {{(W-1){1'b0}}, 1'b1};
                r_x    <= i_in.left_operand[W-1:0];
                r_y    <= i_in.right_operand[W-1:0];
                if (i_in.command == ica_pkg::CMD_DIV || i_in.command == ica_pkg::CMD_REM) begin
                    r_quo <= i_in.left_operand[W-1] ? -i_in.left_operand[W-1:0]
                                                    : i_in.left_operand[W-1:0];
                    r_b   <= i_in.right_operand[W-1] ? -i_in.right_operand[W-1:0]
                                                     : i_in.right_operand[W-1:0];
                end else begin
                    r_quo <= '0;
                    r_b   <= i_in.right_operand[W-1:0];
                end
            end
            ica_pkg::OP_MUL_STEP: begin
                r_acc <= ((i_ctrl.part == 2'd0) ? '0 : r_acc) + w_sh;
            end
            ica_pkg::OP_POW_STEP: begin
                // r_quo accumulates product; r_acc keeps power result between steps.
                r_quo <= ((i_ctrl.part == 2'd0) ? '0 : r_quo) + w_sh;
                if (i_ctrl.part == 2'd2) begin
                    if (i_ctrl.sq) begin
                        r_x <= r_quo + w_sh;
                        r_y <= r_quo + w_sh;
                        r_b <= r_b >> 1;
                    end else begin
                        r_acc <= r_quo + w_sh;
                    end
                end
            end
            ica_pkg::OP_DIV_STEP: begin
                r_quo <= {r_quo[W-2:0], ~w_trial[W]};
                r_rem <= w_trial[W] ? w_rem_sh : w_trial[W-1:0];
            end
            default: ;
        endcase
    end

    // Output register, loaded when the controller finishes a transaction.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == ica_pkg::OP_FINISH) begin
            o_result <= (r_cmd == ica_pkg::CMD_MUL) ? r_acc :
                        (r_cmd == ica_pkg::CMD_POW) ? (r_eneg ? '0 : r_acc) : w_res;
            o_err    <= (r_cmd == ica_pkg::CMD_DIV || r_cmd == ica_pkg::CMD_REM) && r_zero;
        end
    end

    assign o_stat.div_zero = r_zero;
    assign o_stat.exp_done = r_eneg || (r_b == '0);
    assign o_stat.exp_bit  = r_b[0];
endmodule

@@ design/ica_controller.sv @@
// Controller state machine of the integer calculator ALU.
`timescale 1ns / 1ps
module ica_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2:0]     i_cmd,
    input  ica_pkg::t_stat i_stat,
    output ica_pkg::t_ctrl o_ctrl,
    output logic           o_busy,
    output logic           o_done
);
    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_MUL, S_DIV, S_POW_ACC, S_POW_SQ, S_FIN, S_OUT}
        t_state;

    t_state r_state;
    logic [2:0] r_cmd;
    logic [ica_pkg::CNT_W-1:0] r_cnt;
    logic [1:0] r_part;

    // Command outputs decoded from the state.
    always_comb begin
        o_ctrl = '{op: ica_pkg::OP_NONE, part: r_part, sq: 1'b0};
        case (r_state)
            S_IDLE:    if (i_start) o_ctrl.op = ica_pkg::OP_LOAD;
            S_MUL:     o_ctrl.op = ica_pkg::OP_MUL_STEP;
            S_DIV:     o_ctrl.op = ica_pkg::OP_DIV_STEP;
            S_POW_ACC: o_ctrl.op = ica_pkg::OP_POW_STEP;
            S_POW_SQ:  begin o_ctrl.op = ica_pkg::OP_POW_STEP; o_ctrl.sq = 1'b1; end
            S_FIN:     o_ctrl.op = ica_pkg::OP_FINISH;
            default:   ;
        endcase
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_OUT;

    // State register with iteration counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= ica_pkg::CMD_ADD;
            r_cnt   <= '0;
            r_part  <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_cmd   <= i_cmd;
                    r_state <= S_DECODE;
                end
                S_DECODE: begin
                    r_part <= '0;
                    r_cnt  <= '0;
                    if (r_cmd == ica_pkg::CMD_MUL) r_state <= S_MUL;
                    else if ((r_cmd == ica_pkg::CMD_DIV || r_cmd == ica_pkg::CMD_REM)
                             && !i_stat.div_zero) r_state <= S_DIV;
                    else if (r_cmd == ica_pkg::CMD_POW && !i_stat.exp_done)
                        r_state <= i_stat.exp_bit ? S_POW_ACC : S_POW_SQ;
                    else r_state <= S_FIN;
                end
                S_MUL: begin
                    r_part <= r_part + 2'd1;
                    if (r_part == 2'd2) r_state <= S_FIN;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ica_pkg::CNT_W'(ica_pkg::DATA_WIDTH - 1)) r_state <= S_FIN;
                end
                S_POW_ACC: begin
                    if (r_part == 2'd2) begin
                        r_part  <= '0;
                        r_state <= S_POW_SQ;
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
                S_POW_SQ: begin
                    if (r_part == 2'd2) begin
                        r_part  <= '0;
                        r_state <= S_DECODE;
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
                S_FIN:   r_state <= S_OUT;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_done) else $error("done must follow finish");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done lasts one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("accepted start must set busy");
`endif
endmodule

@@ design/integer_calculator_alu_unit.sv @@
// Top level of the integer calculator ALU: controller and datapath.
// Flow: after start the command is decoded; add, sub, min, max and zero-divisor cases go to finish;
// mul sums partial products; div and rem take one quotient bit per cycle (shift-subtract divider);
// pow squares the base per exponent bit up to the highest set bit, multiplying it in per set bit.
// One transaction at a time: busy stays high until the strobe cycle ends; the receiver cannot stall.
// Reset (synchronous, active low) returns the controller to idle; a transaction in progress is dropped.
`timescale 1ns / 1ps
module integer_calculator_alu_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ica_pkg::t_in  i_data,
    output logic          o_strobe,
    output ica_pkg::t_out o_data
);
    ica_pkg::t_ctrl w_ctrl;
    ica_pkg::t_stat w_stat;
    logic [ica_pkg::DATA_WIDTH-1:0] w_res;
    logic w_err;

    ica_controller u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_cmd(i_data.command),
        .i_stat(w_stat), .o_ctrl(w_ctrl), .o_busy(busy), .o_done(o_strobe)
    );

    ica_datapath u_dp (
        .i_clk, .i_in(i_data), .i_ctrl(w_ctrl), .o_stat(w_stat),
        .o_result(w_res), .o_err(w_err)
    );

    assign o_data.result_value = 64'(signed'(w_res));
    assign o_data.status = w_err;
endmodule
